/* src/dsp_pkg.sv */
// dsp_pkg: shared widths, limits and register indexes for the dag shortest path block
// no dependencies; compiled first
package dsp_pkg;

    localparam int NODE_W     = 5;
    localparam int NODES      = 32;
    localparam int CNT_W      = 6;
    localparam int WEIGHT_W   = 16;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 1'd1;

    // int max / int min of the distance range
    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7fff_ffff;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_count;

endpackage

/* src/dsp_in_if.sv */
// dsp_in_if: input channel, one beat adds an edge or starts a run
// depends on dsp_pkg
interface dsp_in_if;
    import dsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [NODE_W-1:0]          edge_from;
    logic [NODE_W-1:0]          edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, mode, edge_from, edge_to, edge_weight, input ready);
    modport sink   (input valid, mode, edge_from, edge_to, edge_weight, output ready);
endinterface

/* src/dsp_out_if.sv */
// dsp_out_if: result channel, one beat per node on a run
// depends on dsp_pkg
interface dsp_out_if;
    import dsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NODE_W-1:0]        node_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     edge_overflow;
    logic                     last;

    modport source (output valid, node_index, distance, reachable, edge_overflow, last,
                    input ready);
    modport sink   (input valid, node_index, distance, reachable, edge_overflow, last,
                    output ready);
endinterface

/* src/dag_shortest_path_top.sv */
// dag_shortest_path_top: shortest distances from one source by depth-first topological order
// depends on dsp_pkg, dsp_in_if, dsp_out_if, dsp_edge_store
//
//  channel   dir  beat content
//  i_in      in   mode, edge_from, edge_to, edge_weight
//  o_out     out  node_index, distance, reachable, edge_overflow, last
//  i_cfg_*   in   write enable, index, data (node_count, source_node)
//
// an edge beat is accepted while idle; a run scans every stored edge for each node the
// search visits, then, in relaxation, for each reached node, then gives one result per node
// edges are read from the edge memory one at a time through a registered read port
// synchronous active-low reset clears control and flags, presets config; memories not cleared
// the block is not ready from the run beat until the last result beat is taken
// results wait in an output register while the sink stalls
module dag_shortest_path_top #(
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dsp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dsp_in_if.sink                           i_in,
    dsp_out_if.source                        o_out
);
    import dsp_pkg::*;

    localparam int EAW = $clog2(MAX_EDGES);

    // sequencer codes
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ROOT     = 4'd1;
    localparam logic [3:0] S_DFS_RD   = 4'd2;
    localparam logic [3:0] S_DFS_CHK  = 4'd3;
    localparam logic [3:0] S_RLX_NODE = 4'd4;
    localparam logic [3:0] S_RLX_DU   = 4'd5;
    localparam logic [3:0] S_RLX_RD   = 4'd6;
    localparam logic [3:0] S_RLX_CHK  = 4'd7;
    localparam logic [3:0] S_RLX_CMP  = 4'd8;
    localparam logic [3:0] S_OUT_RD   = 4'd9;
    localparam logic [3:0] S_OUT_LD   = 4'd10;
    localparam logic [3:0] S_OUT_WAIT = 4'd11;

    // config registers
    logic [CNT_W-1:0]  r_node_count;
    logic [NODE_W-1:0] r_source;
    logic [CNT_W-1:0]  w_n;

    // sequencer state
    logic [3:0]        r_state;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_root;
    logic [CNT_W-1:0]  r_depth;
    logic [CNT_W-1:0]  r_post;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_i;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_t;
    logic [EAW:0]      r_cur;
    logic [DIST_W-1:0] r_du;
    logic [DIST_W-1:0] r_cand;
    logic [NODES-1:0]  r_visited;
    logic [NODES-1:0]  r_reached;

    // dfs stack and topological order, read at the top only
    logic [NODE_W-1:0] r_stk_node [NODES];
    logic [EAW:0]      r_stk_cur  [NODES];
    logic [NODE_W-1:0] r_topo     [NODES];

    // distance memory, one registered read port
    logic [DIST_W-1:0] r_dist_mem [NODES];
    logic [DIST_W-1:0] r_dist_rd;
    logic [NODE_W-1:0] w_dist_raddr;
    logic              w_dist_we;
    logic [NODE_W-1:0] w_dist_waddr;
    logic [DIST_W-1:0] w_dist_wdata;

    // result register
    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_reach;
    logic              r_out_ovf;
    logic              r_out_last;

    // edge store
    logic [NODE_W-1:0]      w_rd_src;
    logic [NODE_W-1:0]      w_rd_dst;
    logic [WEIGHT_BITS-1:0] w_rd_w;
    logic [EAW:0]           w_total;
    logic                   w_overflow;
    logic                   w_clear;

    logic              w_acc;
    logic              w_add;
    logic              w_run;
    logic [NODE_W-1:0] w_top;
    logic [NODE_W-1:0] w_below;
    logic [NODE_W-1:0] w_u;
    logic              w_live;
    logic              w_hit;
    logic [DIST_W:0]   w_sum;
    logic [DIST_W-1:0] w_sat;
    logic              w_src_ok;

    // node count clamp: zero acts as one, above the limit acts as the limit
    always_comb begin
        priority if (r_node_count == '0) begin
            w_n = CNT_W'(1);
        end else if (r_node_count > CNT_W'(NODES)) begin
            w_n = CNT_W'(NODES);
        end else begin
            w_n = r_node_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(NODES);
            r_source     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_COUNT:  r_node_count <= i_cfg_data;
                CFG_SOURCE_NODE: r_source     <= i_cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_add      = w_acc && !i_in.mode;
    assign w_run      = w_acc && i_in.mode;
    assign w_src_ok   = ({1'b0, r_source} < w_n);
    assign w_clear    = (r_state == S_OUT_WAIT) && o_out.ready && r_out_last;

    dsp_edge_store #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_edges (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_add      (w_add),
        .i_from     (i_in.edge_from),
        .i_to       (i_in.edge_to),
        .i_weight   (i_in.edge_weight),
        .i_n        (w_n),
        .i_clear    (w_clear),
        .i_rd_addr  (r_cur[EAW-1:0]),
        .o_rd_src   (w_rd_src),
        .o_rd_dst   (w_rd_dst),
        .o_rd_w     (w_rd_w),
        .o_total    (w_total),
        .o_overflow (w_overflow)
    );

    // stack top and the entry under it
    assign w_top   = NODE_W'(r_depth - 1'b1);
    assign w_below = NODE_W'(r_depth - 2'd2);
    assign w_u     = r_topo[NODE_W'(r_k - 1'b1)];

    // edge endpoints inside the node range of this run
    assign w_live = ({1'b0, w_rd_src} < r_n) && ({1'b0, w_rd_dst} < r_n);
    assign w_hit  = (w_rd_src == r_node) && w_live && !r_visited[w_rd_dst] &&
                    (r_depth < CNT_W'(NODES));

    // candidate distance, formed one bit wider and saturated
    assign w_sum = {r_du[DIST_W-1], r_du} +
                   {{(DIST_W + 1 - WEIGHT_BITS){w_rd_w[WEIGHT_BITS-1]}}, w_rd_w};
    always_comb begin
        priority if (w_sum[DIST_W] != w_sum[DIST_W-1]) begin
            w_sat = w_sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
            w_sat = w_sum[DIST_W-1:0];
        end
    end

    // distance read address follows the state that needs the data next cycle
    always_comb begin
        unique case (r_state)
            S_RLX_NODE: w_dist_raddr = w_u;
            S_RLX_CHK:  w_dist_raddr = w_rd_dst;
            S_OUT_RD:   w_dist_raddr = r_i[NODE_W-1:0];
            default:    w_dist_raddr = r_node;
        endcase
    end

    // source starts at distance zero; relaxation writes targets that are newly reached or improved
    always_comb begin
        w_dist_we    = 1'b0;
        w_dist_waddr = r_t;
        w_dist_wdata = r_cand;
        if (w_run) begin
            w_dist_we    = 1'b1;
            w_dist_waddr = r_source;
            w_dist_wdata = '0;
        end else if (r_state == S_RLX_CMP) begin
            w_dist_we = !r_reached[r_t] || ($signed(r_cand) < $signed(r_dist_rd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dist_we) begin
            r_dist_mem[w_dist_waddr] <= w_dist_wdata;
        end
        r_dist_rd <= r_dist_mem[w_dist_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_visited   <= '0;
            r_reached   <= '0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_post      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_run) begin
                        r_n       <= w_n;
                        r_root    <= '0;
                        r_post    <= '0;
                        r_visited <= '0;
                        r_reached <= w_src_ok ? (NODES'(1) << r_source) : '0;
                        r_state   <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    priority if (r_root >= r_n) begin
                        r_k     <= r_post;
                        r_state <= S_RLX_NODE;
                    end else if (r_visited[r_root[NODE_W-1:0]]) begin
                        r_root <= r_root + 1'b1;
                    end else begin
                        r_stk_node[0]                   <= r_root[NODE_W-1:0];
                        r_node                          <= r_root[NODE_W-1:0];
                        r_visited[r_root[NODE_W-1:0]]   <= 1'b1;
                        r_cur                           <= '0;
                        r_depth                         <= CNT_W'(1);
                        r_state                         <= S_DFS_RD;
                    end
                end
                S_DFS_RD: begin
                    if (r_cur < w_total) begin
                        r_state <= S_DFS_CHK;
                    end else begin
                        // no edge left: node finished, append to postorder and pop
                        if (r_post < CNT_W'(NODES)) begin
                            r_topo[r_post[NODE_W-1:0]] <= r_node;
                            r_post                     <= r_post + 1'b1;
                        end
                        r_depth <= r_depth - 1'b1;
                        if (r_depth == CNT_W'(1)) begin
                            r_root  <= r_root + 1'b1;
                            r_state <= S_ROOT;
                        end else begin
                            r_node <= r_stk_node[w_below];
                            r_cur  <= r_stk_cur[w_below];
                        end
                    end
                end
                S_DFS_CHK: begin
                    if (w_hit) begin
                        r_stk_cur[w_top]                  <= r_cur + 1'b1;
                        r_stk_node[r_depth[NODE_W-1:0]]   <= w_rd_dst;
                        r_visited[w_rd_dst]               <= 1'b1;
                        r_node                            <= w_rd_dst;
                        r_cur                             <= '0;
                        r_depth                           <= r_depth + 1'b1;
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                    r_state <= S_DFS_RD;
                end
                S_RLX_NODE: begin
                    priority if (r_k == '0) begin
                        r_i     <= '0;
                        r_state <= S_OUT_RD;
                    end else if (!r_reached[w_u]) begin
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_node  <= w_u;
                        r_cur   <= '0;
                        r_state <= S_RLX_DU;
                    end
                end
                S_RLX_DU: begin
                    r_du    <= r_dist_rd;
                    r_state <= S_RLX_RD;
                end
                S_RLX_RD: begin
                    if (r_cur < w_total) begin
                        r_state <= S_RLX_CHK;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_RLX_NODE;
                    end
                end
                S_RLX_CHK: begin
                    if ((w_rd_src == r_node) && w_live) begin
                        r_t     <= w_rd_dst;
                        r_cand  <= w_sat;
                        r_state <= S_RLX_CMP;
                    end else begin
                        r_cur   <= r_cur + 1'b1;
                        r_state <= S_RLX_RD;
                    end
                end
                S_RLX_CMP: begin
                    if (w_dist_we) begin
                        r_reached[r_t] <= 1'b1;
                        // a self loop moves the distance this node relaxes from
                        if (r_t == r_node) begin
                            r_du <= r_cand;
                        end
                    end
                    r_cur   <= r_cur + 1'b1;
                    r_state <= S_RLX_RD;
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_node  <= r_i[NODE_W-1:0];
                    r_out_reach <= r_reached[r_i[NODE_W-1:0]];
                    r_out_dist  <= r_reached[r_i[NODE_W-1:0]] ? r_dist_rd : '0;
                    r_out_ovf   <= w_overflow;
                    r_out_last  <= ((r_i + 1'b1) == r_n);
                    r_state     <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_visited <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.node_index    = r_out_node;
    assign o_out.distance      = r_out_dist;
    assign o_out.reachable     = r_out_reach;
    assign o_out.edge_overflow = r_out_ovf;
    assign o_out.last          = r_out_last;

    // a result beat is only offered while the input side is closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("result offered while input ready");

    // the final result names the highest node of the run
    a_last_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> ({1'b0, o_out.node_index} == (r_n - 1'b1)))
        else $error("last flag on wrong node");

    // stack depth and postorder length never pass the node limit
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth <= CNT_W'(NODES)) && (r_post <= CNT_W'(NODES)))
        else $error("stack or postorder overrun");

    // an unreachable node reports distance zero
    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.reachable) |-> (o_out.distance == '0))
        else $error("unreachable node with nonzero distance");
endmodule

/* src/dsp_edge_store.sv */
// dsp_edge_store: edge memory in arrival order, edge count and drop flag
// depends on dsp_pkg
module dsp_edge_store #(
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_add,
    input  logic [dsp_pkg::NODE_W-1:0]          i_from,
    input  logic [dsp_pkg::NODE_W-1:0]          i_to,
    input  logic [dsp_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic [dsp_pkg::CNT_W-1:0]           i_n,
    input  logic                                i_clear,
    input  logic [$clog2(MAX_EDGES)-1:0]        i_rd_addr,
    output logic [dsp_pkg::NODE_W-1:0]          o_rd_src,
    output logic [dsp_pkg::NODE_W-1:0]          o_rd_dst,
    output logic [WEIGHT_BITS-1:0]              o_rd_w,
    output logic [$clog2(MAX_EDGES):0]          o_total,
    output logic                                o_overflow
);
    import dsp_pkg::*;

    localparam int EAW   = $clog2(MAX_EDGES);
    localparam int WORD_W = 2 * NODE_W + WEIGHT_BITS;

    logic [WORD_W-1:0] r_mem [MAX_EDGES];
    logic [WORD_W-1:0] r_rd;
    logic [EAW:0]      r_total;
    logic              r_overflow;
    logic [23:0]       w_wext;
    logic              w_drop;

    assign w_wext = {{(24 - WEIGHT_W){1'b0}}, i_weight};
    assign w_drop = ({1'b0, i_from} >= i_n) || ({1'b0, i_to} >= i_n) ||
                    (r_total >= (EAW + 1)'(MAX_EDGES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_overflow <= 1'b0;
        end else if (i_clear) begin
            r_total    <= '0;
            r_overflow <= 1'b0;
        end else if (i_add) begin
            if (w_drop) begin
                r_overflow <= 1'b1;
            end else begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_add && !w_drop) begin
            r_mem[r_total[EAW-1:0]] <= {i_from, i_to, w_wext[WEIGHT_BITS-1:0]};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_src   = r_rd[WORD_W-1 -: NODE_W];
    assign o_rd_dst   = r_rd[WEIGHT_BITS +: NODE_W];
    assign o_rd_w     = r_rd[WEIGHT_BITS-1:0];
    assign o_total    = r_total;
    assign o_overflow = r_overflow;
endmodule
